FILE: hdl/rbf_pkg.sv
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared widths, register indexes and beat types of the RGB 3x3 box filter.
// ----------------------------------------------------------------------------
package rbf_pkg;

	localparam int MAX_LINE   = 1024;
	localparam int COL_W      = $clog2(MAX_LINE);
	localparam int CNT_W      = $clog2(MAX_LINE + 1);
	localparam int ROW_W      = 16;
	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int OUT_COL_W  = 10;
	localparam int LEN_CFG_W  = 11;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CSUM_W     = CH_W + 2;
	localparam int SUM_W      = CH_W + 4;

	// Division by nine: multiply by ceil(2^16 / 9) and drop 16 bits.
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 16;
	localparam logic [RECIP_W-1:0] RECIP_NINE = RECIP_W'(7282);

	localparam int LEN_RESET_INT = (100 > MAX_LINE) ? MAX_LINE : 100;
	localparam logic [CNT_W-1:0] LEN_RESET   = CNT_W'(LEN_RESET_INT);
	localparam logic [ROW_W-1:0] LINES_RESET = ROW_W'(100);

	localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LINES = CFG_IDX_W'(1);

	typedef struct packed {
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0]      red_out;
		logic [CH_W-1:0]      green_out;
		logic [CH_W-1:0]      blue_out;
		logic [ROW_W-1:0]     out_row;
		logic [OUT_COL_W-1:0] out_col;
		logic                 is_smoothed;
		logic                 last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} pos_t;

	typedef struct packed {
		logic [CNT_W-1:0] len;
		logic [ROW_W-1:0] lines;
	} geom_t;

	typedef struct packed {
		logic [CSUM_W-1:0] r;
		logic [CSUM_W-1:0] g;
		logic [CSUM_W-1:0] b;
	} csum_t;

	typedef struct packed {
		logic [SUM_W-1:0] r;
		logic [SUM_W-1:0] g;
		logic [SUM_W-1:0] b;
	} rgb_sum_t;

	typedef struct packed {
		in_item_t pix;
		pos_t     pos;
		rgb_sum_t sum;
		logic     smooth;
		logic     border;
	} emit_item_t;

endpackage

FILE: hdl/rbf_ram.sv
// ----------------------------------------------------------------------------
// rbf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module rbf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/rbf_pos.sv
// ----------------------------------------------------------------------------
// rbf_pos
// Geometry registers and the row and column counters of the pixel stream.
// ----------------------------------------------------------------------------
module rbf_pos import rbf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  step,
	output geom_t                 geom,
	output pos_t                  pos
);

	logic [CNT_W-1:0]     len_q;
	logic [ROW_W-1:0]     lines_q;
	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [LEN_CFG_W-1:0] len_raw;
	logic [CNT_W-1:0]     len_new;
	logic [ROW_W-1:0]     lines_new;
	logic [CNT_W-1:0]     col_cur;
	logic [ROW_W-1:0]     row_cur;
	logic [CNT_W-1:0]     col_nxt;
	logic [ROW_W-1:0]     row_nxt;

	always_comb begin
		len_raw = cfg_data[LEN_CFG_W-1:0];
		if (len_raw == '0) begin
			len_new = CNT_W'(1);
		end else if (32'(len_raw) > MAX_LINE) begin
			len_new = CNT_W'(MAX_LINE);
		end else begin
			len_new = CNT_W'(len_raw);
		end
		lines_new = (cfg_data == '0) ? ROW_W'(1) : cfg_data;
	end

	// The stored position may lie beyond a line or frame that was just shortened.
	always_comb begin
		col_cur = CNT_W'(col_q);
		row_cur = row_q;
		if (col_cur >= len_q) begin
			col_cur = '0;
			row_cur = row_q + ROW_W'(1);
		end
		if (row_cur >= lines_q) begin
			row_cur = '0;
		end
		col_nxt = col_cur + CNT_W'(1);
		row_nxt = row_cur;
		if (col_nxt >= len_q) begin
			col_nxt = '0;
			row_nxt = row_cur + ROW_W'(1);
			if (row_nxt >= lines_q) begin
				row_nxt = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= LEN_RESET;
			lines_q <= LINES_RESET;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_LINE_LENGTH: len_q   <= len_new;
					REG_FRAME_LINES: lines_q <= lines_new;
					default: ;
				endcase
			end
			if (step) begin
				col_q <= COL_W'(col_nxt);
				row_q <= row_nxt;
			end
		end
	end

	assign geom.len   = len_q;
	assign geom.lines = lines_q;
	assign pos.row    = row_cur;
	assign pos.col    = COL_W'(col_cur);

endmodule

FILE: hdl/rbf_window.sv
// ----------------------------------------------------------------------------
// rbf_window
// Line stores, 3x3 window column sums and border classification of a pixel.
// ----------------------------------------------------------------------------
module rbf_window import rbf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  in_item_t   pix,
	input  pos_t       pos,
	input  geom_t      geom,
	output logic       pix_ready,
	output logic       itm_valid,
	input  logic       itm_ready,
	output emit_item_t itm
);

	logic       valid_s1;
	in_item_t   pix_s1;
	pos_t       pos_s1;
	logic       fwd_q;
	in_item_t   fwd_up_q;
	in_item_t   fwd_lo_q;
	csum_t      cs_old_q;
	csum_t      cs_new_q;
	logic [PIX_W-1:0] up_rdata;
	logic [PIX_W-1:0] lo_rdata;
	logic [COL_W-1:0] raddr;
	in_item_t   up_eff;
	in_item_t   lo_eff;
	csum_t      cs_cur;
	logic       smooth;
	logic       border;
	logic       has_res;
	logic       s1_adv;

	assign raddr = accept ? pos.col : pos_s1.col;

	rbf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE)) u_upper (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (pos_s1.col),
		.wdata (lo_eff),
		.raddr (raddr),
		.rdata (up_rdata)
	);

	rbf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE)) u_lower (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (pos_s1.col),
		.wdata (pix_s1),
		.raddr (raddr),
		.rdata (lo_rdata)
	);

	// With a one-pixel line the column is read in the cycle its last write lands.
	assign up_eff = fwd_q ? fwd_up_q : in_item_t'(up_rdata);
	assign lo_eff = fwd_q ? fwd_lo_q : in_item_t'(lo_rdata);

	always_comb begin
		cs_cur.r = CSUM_W'(up_eff.red_in) + CSUM_W'(lo_eff.red_in) + CSUM_W'(pix_s1.red_in);
		cs_cur.g = CSUM_W'(up_eff.green_in) + CSUM_W'(lo_eff.green_in)
			+ CSUM_W'(pix_s1.green_in);
		cs_cur.b = CSUM_W'(up_eff.blue_in) + CSUM_W'(lo_eff.blue_in) + CSUM_W'(pix_s1.blue_in);
		smooth = (pos_s1.row >= ROW_W'(2)) && (pos_s1.col >= COL_W'(2));
		border = (pos_s1.row == '0) || (pos_s1.col == '0)
			|| ((ROW_W + 1)'(pos_s1.row) + (ROW_W + 1)'(1) == (ROW_W + 1)'(geom.lines))
			|| (CNT_W'(pos_s1.col) + CNT_W'(1) == geom.len);
		has_res = smooth || border;
		itm.pix    = pix_s1;
		itm.pos    = pos_s1;
		itm.sum.r  = SUM_W'(cs_old_q.r) + SUM_W'(cs_new_q.r) + SUM_W'(cs_cur.r);
		itm.sum.g  = SUM_W'(cs_old_q.g) + SUM_W'(cs_new_q.g) + SUM_W'(cs_cur.g);
		itm.sum.b  = SUM_W'(cs_old_q.b) + SUM_W'(cs_new_q.b) + SUM_W'(cs_cur.b);
		itm.smooth = smooth;
		itm.border = border;
	end

	assign itm_valid = valid_s1 && has_res;
	assign s1_adv    = valid_s1 && (itm_ready || !has_res);
	assign pix_ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_q    <= 1'b0;
			cs_old_q <= '0;
			cs_new_q <= '0;
		end else begin
			if (pix_ready) begin
				valid_s1 <= accept;
			end
			fwd_q <= accept && s1_adv && (pos.col == pos_s1.col);
			if (s1_adv) begin
				cs_old_q <= cs_new_q;
				cs_new_q <= cs_cur;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix;
			pos_s1 <= pos;
		end
		if (s1_adv) begin
			fwd_up_q <= lo_eff;
			fwd_lo_q <= pix_s1;
		end
	end

endmodule

FILE: hdl/rbf_emit.sv
// ----------------------------------------------------------------------------
// rbf_emit
// Divides the window sums by nine and issues up to two result beats per pixel.
// ----------------------------------------------------------------------------
module rbf_emit import rbf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       itm_valid,
	input  emit_item_t itm,
	output logic       itm_ready,
	output logic       res_valid,
	input  logic       res_ready,
	output out_item_t  res_data
);

	logic       valid_s2;
	emit_item_t itm_s2;
	logic       pend_smooth_s2;
	logic       pend_border_s2;
	logic       res_v_q;
	out_item_t  res_q;
	out_item_t  res_nxt;
	logic       load;
	logic       done;

	function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
		logic [SUM_W+RECIP_W-1:0] p;
		p = (SUM_W + RECIP_W)'(s) * (SUM_W + RECIP_W)'(RECIP_NINE);
		return p[RECIP_SHIFT +: CH_W];
	endfunction

	assign load      = valid_s2 && (!res_v_q || res_ready);
	assign done      = load && !(pend_smooth_s2 && pend_border_s2);
	assign itm_ready = !valid_s2 || done;

	always_comb begin
		if (pend_smooth_s2) begin
			res_nxt.red_out     = div9(itm_s2.sum.r);
			res_nxt.green_out   = div9(itm_s2.sum.g);
			res_nxt.blue_out    = div9(itm_s2.sum.b);
			res_nxt.out_row     = itm_s2.pos.row - ROW_W'(1);
			res_nxt.out_col     = OUT_COL_W'(itm_s2.pos.col - COL_W'(1));
			res_nxt.is_smoothed = 1'b1;
			res_nxt.last_of_run = !pend_border_s2;
		end else begin
			res_nxt.red_out     = itm_s2.pix.red_in;
			res_nxt.green_out   = itm_s2.pix.green_in;
			res_nxt.blue_out    = itm_s2.pix.blue_in;
			res_nxt.out_row     = itm_s2.pos.row;
			res_nxt.out_col     = OUT_COL_W'(itm_s2.pos.col);
			res_nxt.is_smoothed = 1'b0;
			res_nxt.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2       <= 1'b0;
			pend_smooth_s2 <= 1'b0;
			pend_border_s2 <= 1'b0;
			res_v_q        <= 1'b0;
		end else begin
			if (itm_ready) begin
				valid_s2 <= itm_valid;
				if (itm_valid) begin
					pend_smooth_s2 <= itm.smooth;
					pend_border_s2 <= itm.border;
				end
			end else if (load) begin
				pend_smooth_s2 <= 1'b0;
			end
			if (load) begin
				res_v_q <= 1'b1;
			end else if (res_ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (itm_ready && itm_valid) begin
			itm_s2 <= itm;
		end
		if (load) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_v_q;
	assign res_data  = res_q;

endmodule

FILE: hdl/rgb_box_filter_3x3.sv
// ----------------------------------------------------------------------------
// rgb_box_filter_3x3
// Streaming 3x3 box filter on RGB pixels in raster order, with border pass-through.
// ----------------------------------------------------------------------------
//  channel | beat          | signals
//  pix     | input pixel   | pix_valid, pix_ready, pix_data
//  res     | result pixel  | res_valid, res_ready, res_data
//  cfg     | register write| cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One pixel is taken per cycle while res does not stall and no pixel holds the input;
// it passes through the window stage, the emit stage and the result register.
// A pixel that yields both a smoothed and a border result loads the single
// result register twice, smoothed beat first, and the input holds meanwhile.
// Reset clears the counters and sets a 100 by 100 frame; the line stores are not
// cleared, and the first two lines of a frame fill them before they are read.
// A stall on res backs up through the two internal stages to pix_ready.
// ----------------------------------------------------------------------------
module rgb_box_filter_3x3 import rbf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  in_item_t              pix_data,
	output logic                  res_valid,
	input  logic                  res_ready,
	output out_item_t             res_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic       accept;
	geom_t      geom;
	pos_t       pos;
	logic       itm_valid;
	logic       itm_ready;
	emit_item_t itm;

	assign cfg_ready = 1'b1;
	assign accept    = pix_valid && pix_ready;

	rbf_pos u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (accept),
		.geom      (geom),
		.pos       (pos)
	);

	rbf_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.pix       (pix_data),
		.pos       (pos),
		.geom      (geom),
		.pix_ready (pix_ready),
		.itm_valid (itm_valid),
		.itm_ready (itm_ready),
		.itm       (itm)
	);

	rbf_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.itm_valid (itm_valid),
		.itm       (itm),
		.itm_ready (itm_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

`ifndef ASSERT_OFF
	a_col_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (CNT_W'(pos.col) < geom.len))
		else $error("accepted pixel lies beyond the line length");

	a_smooth_interior: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.is_smoothed |-> (res_data.out_row != '0)
			&& (res_data.out_col != '0))
		else $error("smoothed result on the first line or column");

	a_border_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.is_smoothed |-> res_data.last_of_run)
		else $error("border result not marked last");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res_data.is_smoothed && !res_data.last_of_run
			|=> res_valid && !res_data.is_smoothed)
		else $error("border result missing after its smoothed partner");
`endif

endmodule
